[sv/asr_pkg.sv]
//------------------------------------------------------------------------------
// asr_pkg
// Types, constants and the CRC-A byte update shared by the anticollision
// select responder and its response burst buffer.
//------------------------------------------------------------------------------
`default_nettype none

package asr_pkg;

	localparam int UID_BYTES   = 4;
	localparam int BURST_DEPTH = UID_BYTES + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	typedef logic [7:0] byte_t;
	typedef logic [$clog2(BURST_DEPTH+1)-1:0] beat_cnt_t;
	typedef logic [3:0] frame_cnt_t;

	localparam byte_t      NVB_AC_START   = 8'h20;
	localparam byte_t      NVB_AC_END     = 8'h70;
	localparam byte_t      SAK_COMPLIANT  = 8'h20;
	localparam logic [15:0] CRC_POLY      = 16'h8408;
	localparam logic [15:0] CRC_PRESET_RST = 16'h6363;
	localparam frame_cnt_t COUNT_MAX      = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UID_WORD   = 2'd0,
		CFG_SAK_VALUE  = 2'd1,
		CFG_CRC_PRESET = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                        valid;
		beat_cnt_t                   count;
		byte_t [BURST_DEPTH-1:0]     data;
	} burst_load_t;

	function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input byte_t b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[sv/asr_burst.sv]
//------------------------------------------------------------------------------
// asr_burst
// Response burst buffer: loads a whole response at once and shifts it out
// one beat per accepted transfer, first byte first.
//------------------------------------------------------------------------------
`default_nettype none

module asr_burst (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire asr_pkg::burst_load_t ld,
	output logic                      free_next,
	output logic                      tx_valid,
	input  wire logic                 tx_stall,
	output asr_pkg::byte_t            tx_byte,
	output logic                      tx_last
);

	asr_pkg::beat_cnt_t                          cnt_q;
	asr_pkg::byte_t [asr_pkg::BURST_DEPTH-1:0]   data_q;
	logic                                        take;

	assign tx_valid  = (cnt_q != '0);
	assign take      = tx_valid && !tx_stall;
	assign tx_byte   = data_q[0];
	assign tx_last   = (cnt_q == asr_pkg::beat_cnt_t'(1));
	assign free_next = (cnt_q == '0) || (take && tx_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ld.valid) begin
			cnt_q <= ld.count;
		end else if (take) begin
			cnt_q <= cnt_q - asr_pkg::beat_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.valid) begin
			data_q <= ld.data;
		end else if (take) begin
			data_q <= {8'h00, data_q[asr_pkg::BURST_DEPTH-1:1]};
		end
	end

	// a new response only lands when the previous one is gone or leaving
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld.valid |-> free_next)
		else $error("burst loaded over a pending response");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= asr_pkg::beat_cnt_t'(asr_pkg::BURST_DEPTH))
		else $error("burst count out of range");

	a_end_of_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tx_last && !ld.valid) |=> !tx_valid)
		else $error("beat shown after final beat");

endmodule

`default_nettype wire

[sv/anticollision_select_responder.sv]
//------------------------------------------------------------------------------
// anticollision_select_responder
// Card-side responder for one cascade level of type A anticollision/select:
// tracks the received frame and answers with UID+BCC or SAK+CRC-A.
//------------------------------------------------------------------------------
// channel | dir | handshake            | payload
// rx      | in  | rx_valid / rx_stall  | rx_byte, rx_last
// tx      | out | tx_valid / tx_stall  | tx_byte, tx_last
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one received beat per cycle while rx_stall is low, held in the input register
// a frame end may load a full response (5 or 3 beats) into the burst buffer
// a frame-end beat waits in the input register while a previous response drains
// reset clears frame state, burst count and registers (crc preset to 0x6363)
//------------------------------------------------------------------------------
`default_nettype none

module anticollision_select_responder (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 rx_valid,
	output logic                                      rx_stall,
	input  wire asr_pkg::byte_t                       rx_byte,
	input  wire logic                                 rx_last,
	output logic                                      tx_valid,
	input  wire logic                                 tx_stall,
	output asr_pkg::byte_t                            tx_byte,
	output logic                                      tx_last,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [asr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [asr_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [31:0]            uid_q;
	asr_pkg::byte_t         sak_q;
	logic [15:0]            crc_preset_q;

	logic                   valid_s1;
	asr_pkg::byte_t         byte_s1;
	logic                   last_s1;

	asr_pkg::frame_cnt_t    count_q;
	asr_pkg::byte_t         nvb_q;
	logic                   match_q;

	asr_pkg::frame_cnt_t    count_nx;
	asr_pkg::byte_t         nvb_nx;
	logic                   match_nx;
	logic                   cmp_en;
	logic [1:0]             uid_sel;
	asr_pkg::byte_t         uid_cur;
	asr_pkg::byte_t         bcc;
	asr_pkg::byte_t         sak;
	logic [15:0]            crc;
	logic                   adv;
	logic                   free_next;
	asr_pkg::burst_load_t   ld;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uid_q        <= '0;
			sak_q        <= '0;
			crc_preset_q <= asr_pkg::CRC_PRESET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				asr_pkg::CFG_UID_WORD:   uid_q        <= cfg_data;
				asr_pkg::CFG_SAK_VALUE:  sak_q        <= cfg_data[7:0];
				asr_pkg::CFG_CRC_PRESET: crc_preset_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	assign rx_stall = valid_s1 && last_s1 && !free_next;
	assign adv      = valid_s1 && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall) begin
			byte_s1 <= rx_byte;
			last_s1 <= rx_last;
		end
	end

	// frame tracking
	always_comb begin
		cmp_en   = (count_q >= 4'd2) && (count_q < 4'(2 + asr_pkg::UID_BYTES));
		uid_sel  = count_q[1:0] - 2'd2;
		uid_cur  = uid_q[{uid_sel, 3'b000} +: 8];
		nvb_nx   = (count_q == 4'd1) ? byte_s1 : nvb_q;
		match_nx = match_q && !(cmp_en && (byte_s1 != uid_cur));
		count_nx = (count_q == asr_pkg::COUNT_MAX) ? count_q : count_q + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			nvb_q   <= '0;
			match_q <= 1'b1;
		end else if (adv) begin
			if (last_s1) begin
				count_q <= '0;
				nvb_q   <= '0;
				match_q <= 1'b1;
			end else begin
				count_q <= count_nx;
				nvb_q   <= nvb_nx;
				match_q <= match_nx;
			end
		end
	end

	// response build
	always_comb begin
		bcc = uid_q[7:0] ^ uid_q[15:8] ^ uid_q[23:16] ^ uid_q[31:24];
		sak = sak_q | asr_pkg::SAK_COMPLIANT;
		crc = asr_pkg::crc_a_byte(crc_preset_q, sak);
		ld  = '0;
		if (adv && last_s1 && (count_nx >= 4'd2)) begin
			priority if (nvb_nx == asr_pkg::NVB_AC_START) begin
				ld.valid = 1'b1;
				ld.count = asr_pkg::beat_cnt_t'(asr_pkg::BURST_DEPTH);
				ld.data  = {bcc, uid_q[31:24], uid_q[23:16], uid_q[15:8], uid_q[7:0]};
			end else if ((nvb_nx == asr_pkg::NVB_AC_END) && match_nx
					&& (count_nx >= 4'(2 + asr_pkg::UID_BYTES))) begin
				ld.valid = 1'b1;
				ld.count = asr_pkg::beat_cnt_t'(3);
				ld.data  = {8'h00, 8'h00, crc[15:8], crc[7:0], sak};
			end else begin
				ld = '0;
			end
		end
	end

	asr_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.free_next (free_next),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.tx_byte   (tx_byte),
		.tx_last   (tx_last)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && last_s1 && tx_valid))
		else $error("input held without a pending response");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (count_q == '0) && match_q && (nvb_q == '0))
		else $error("frame state not cleared at frame end");

	a_no_resp_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ld.valid |-> (adv && last_s1))
		else $error("response loaded outside a frame end");

endmodule

`default_nettype wire

[tb/anticollision_select_responder_test.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// anticollision_select_responder_test
// Self-checking bench for the type A anticollision/select responder. Reader
// frames go in byte by byte under random gaps and back-pressure. Every
// accepted byte updates a local model of the frame tracker, and each
// response beat is checked in order against the bytes that model predicts.
//------------------------------------------------------------------------------

module anticollision_select_responder_test;

	localparam int             HALF_PERIOD  = 6;
	localparam int             DRAIN_CYCLES = 16;
	localparam int             TIMEOUT_NS   = 4_000_000;
	localparam asr_pkg::byte_t REQA_CMD     = 8'h26;
	localparam asr_pkg::byte_t SEL_CL1      = 8'h93;
	localparam asr_pkg::byte_t NVB_PARTIAL  = 8'h45;

	typedef struct packed {
		asr_pkg::byte_t data;
		logic           last;
	} beat_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           rx_valid = 1'b0;
	logic                           rx_stall;
	asr_pkg::byte_t                 rx_byte = '0;
	logic                           rx_last = 1'b0;
	logic                           tx_valid;
	logic                           tx_stall = 1'b0;
	asr_pkg::byte_t                 tx_byte;
	logic                           tx_last;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [asr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [asr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// frame bytes waiting to be sent, response bytes still due
	beat_t rx_q[$];
	beat_t resp_due[$];
	beat_t next_beat;
	beat_t got;
	logic  rx_taken = 1'b0;
	int    rx_gap_pct = 0;
	int    tx_stall_pct = 0;
	int    mismatches = 0;

	// register copies and frame tracker state
	logic [31:0]         uid_reg = '0;
	asr_pkg::byte_t      sak_reg = '0;
	logic [15:0]         crc_preset_reg = asr_pkg::CRC_PRESET_RST;
	asr_pkg::frame_cnt_t frame_len = '0;
	asr_pkg::byte_t      frame_nvb = '0;
	logic                frame_match = 1'b1;

	anticollision_select_responder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.rx_last   (rx_last),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.tx_byte   (tx_byte),
		.tx_last   (tx_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever begin
			#HALF_PERIOD clk = ~clk;
		end
	end

	function automatic logic [15:0] crc_a_update(input logic [15:0] seed,
			input asr_pkg::byte_t b);
		logic [15:0] c;
		logic        fb;
		c = seed;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ asr_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic predict_response(input asr_pkg::byte_t b, input logic last);
		asr_pkg::byte_t bcc;
		asr_pkg::byte_t sak;
		logic [15:0]    crc;
		if (frame_len == 1) begin
			frame_nvb = b;
		end
		if (frame_len >= 2 && frame_len < 2 + asr_pkg::UID_BYTES) begin
			if (b != uid_reg[(frame_len - 2) * 8 +: 8]) begin
				frame_match = 1'b0;
			end
		end
		if (frame_len != asr_pkg::COUNT_MAX) begin
			frame_len++;
		end
		if (last) begin
			if (frame_len >= 2) begin
				if (frame_nvb == asr_pkg::NVB_AC_START) begin
					bcc = '0;
					for (int k = 0; k < asr_pkg::UID_BYTES; k++) begin
						bcc ^= uid_reg[k * 8 +: 8];
						resp_due.push_back('{uid_reg[k * 8 +: 8], 1'b0});
					end
					resp_due.push_back('{bcc, 1'b1});
				end else if (frame_nvb == asr_pkg::NVB_AC_END && frame_match
						&& frame_len >= 2 + asr_pkg::UID_BYTES) begin
					sak = sak_reg | asr_pkg::SAK_COMPLIANT;
					crc = crc_a_update(crc_preset_reg, sak);
					resp_due.push_back('{sak, 1'b0});
					resp_due.push_back('{crc[7:0], 1'b0});
					resp_due.push_back('{crc[15:8], 1'b1});
				end
			end
			frame_len = '0;
			frame_nvb = '0;
			frame_match = 1'b1;
		end
	endtask

	// driver: one beat offered at a time, held until taken
	always @(negedge clk) begin
		tx_stall <= ($urandom_range(99) < tx_stall_pct);
		if (!rx_valid || rx_taken) begin
			if (rx_q.size() != 0 && $urandom_range(99) >= rx_gap_pct) begin
				next_beat = rx_q.pop_front();
				rx_byte <= next_beat.data;
				rx_last <= next_beat.last;
				rx_valid <= 1'b1;
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rx_taken <= rx_valid && !rx_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (asr_pkg::cfg_reg_t'(cfg_index))
					asr_pkg::CFG_UID_WORD:   uid_reg = cfg_data;
					asr_pkg::CFG_SAK_VALUE:  sak_reg = cfg_data[7:0];
					asr_pkg::CFG_CRC_PRESET: crc_preset_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (rx_valid && !rx_stall) begin
				predict_response(rx_byte, rx_last);
			end
			if (tx_valid && !tx_stall) begin
				if (resp_due.size() == 0) begin
					report_mismatch($sformatf("unexpected beat %02h last %0b",
						tx_byte, tx_last));
				end else begin
					got = resp_due.pop_front();
					if (tx_byte !== got.data) begin
						report_mismatch($sformatf("tx_byte %02h, want %02h",
							tx_byte, got.data));
					end
					if (tx_last !== got.last) begin
						report_mismatch($sformatf("tx_last %0b, want %0b",
							tx_last, got.last));
					end
				end
			end
		end
	end

	task automatic write_reg(input asr_pkg::cfg_reg_t idx,
			input logic [asr_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (rx_q.size() != 0 || rx_valid || resp_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_frame(input asr_pkg::byte_t bytes[$]);
		foreach (bytes[i]) begin
			rx_q.push_back('{bytes[i], i == bytes.size() - 1});
		end
	endtask

	task automatic queue_random_frame(output int n);
		asr_pkg::byte_t frame[$];
		asr_pkg::byte_t bcc;
		int             pick;
		int             extra;
		pick = $urandom_range(99);
		frame = {};
		frame.push_back(asr_pkg::byte_t'($urandom_range(255)));
		if (pick < 30) begin
			frame.push_back(asr_pkg::NVB_AC_START);
			if ($urandom_range(4) == 0) begin
				extra = $urandom_range(1, 4);
				repeat (extra) frame.push_back(asr_pkg::byte_t'($urandom));
			end
		end else if (pick < 75) begin
			frame.push_back(asr_pkg::NVB_AC_END);
			bcc = '0;
			for (int k = 0; k < asr_pkg::UID_BYTES; k++) begin
				bcc ^= uid_reg[k * 8 +: 8];
				frame.push_back(uid_reg[k * 8 +: 8]);
			end
			frame.push_back(bcc);
			frame.push_back(asr_pkg::byte_t'($urandom));
			frame.push_back(asr_pkg::byte_t'($urandom));
			// wrong uid byte
			if ($urandom_range(3) == 0) begin
				frame[2 + $urandom_range(3)] ^=
					asr_pkg::byte_t'(8'h01 << $urandom_range(7));
			end
			// truncated select or trailing junk
			if ($urandom_range(5) == 0) begin
				extra = $urandom_range(2, 5);
				while (frame.size() > extra) begin
					frame.delete(frame.size() - 1);
				end
			end else if ($urandom_range(5) == 0) begin
				extra = $urandom_range(1, 10);
				repeat (extra) frame.push_back(asr_pkg::byte_t'($urandom));
			end
		end else begin
			extra = $urandom_range(0, 7);
			repeat (extra) frame.push_back(asr_pkg::byte_t'($urandom));
		end
		n = frame.size();
		push_frame(frame);
	endtask

	task automatic run_random(input int beats);
		int sent;
		int n;
		sent = 0;
		while (sent < beats) begin
			queue_random_frame(n);
			sent += n;
		end
		wait_drained();
	endtask

	initial begin
		asr_pkg::byte_t frame[$];
		rx_gap_pct = 23;
		tx_stall_pct = 79;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: lone byte, then anticollision
		frame = {REQA_CMD};
		push_frame(frame);
		frame = {SEL_CL1, asr_pkg::NVB_AC_START};
		push_frame(frame);
		wait_drained();

		write_reg(asr_pkg::CFG_UID_WORD, 32'hFFFF_FFFF);
		write_reg(asr_pkg::CFG_SAK_VALUE, 32'h0000_00FF);
		write_reg(asr_pkg::CFG_CRC_PRESET, 32'h0000_0000);
		// short select, unsupported nvb, long select past counter saturation
		frame = {SEL_CL1, asr_pkg::NVB_AC_END, 8'hFF};
		push_frame(frame);
		frame = {SEL_CL1, NVB_PARTIAL};
		push_frame(frame);
		frame = {SEL_CL1, asr_pkg::NVB_AC_END, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
			8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7E, 8'h3C, 8'hC3, 8'h00};
		push_frame(frame);
		wait_drained();

		write_reg(asr_pkg::CFG_UID_WORD, $urandom);
		write_reg(asr_pkg::CFG_SAK_VALUE, $urandom_range(255));
		write_reg(asr_pkg::CFG_CRC_PRESET, asr_pkg::CRC_PRESET_RST);
		run_random(26);

		rx_gap_pct = 79;
		tx_stall_pct = 23;
		write_reg(asr_pkg::CFG_UID_WORD, $urandom);
		write_reg(asr_pkg::CFG_SAK_VALUE, 32'h0000_0000);
		write_reg(asr_pkg::CFG_CRC_PRESET, 32'h0000_FFFF);
		run_random(26);

		rx_gap_pct = 0;
		tx_stall_pct = 0;
		write_reg(asr_pkg::CFG_UID_WORD, $urandom);
		write_reg(asr_pkg::CFG_SAK_VALUE, $urandom_range(255));
		write_reg(asr_pkg::CFG_CRC_PRESET, $urandom_range(65535));
		run_random(26);

		if (mismatches == 0 && resp_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#TIMEOUT_NS;
		$display("%0t ns: timeout, %0d response beats outstanding", $time,
			resp_due.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
